// File: rtl/nrhs_pkg.sv
// nrhs_pkg: shared constants for the nearest-request head scheduler.
// No dependencies.
`timescale 1ns / 1ps
package nrhs_pkg;
    localparam int PosW   = 10;
    localparam int Positions = 1024;
    localparam int CntW   = 16;
    localparam int SumW   = 48;
    localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};
    localparam logic [SumW-1:0] SumMax   = {SumW{1'b1}};
    localparam logic [PosW-1:0] TrackLastReset = PosW'(Positions - 1);
    localparam logic ActAdd   = 1'b0;
    localparam logic ActServe = 1'b1;
endpackage

// File: rtl/nrhs_count_ram.sv
// nrhs_count_ram: pending-count memory, one write and one registered read port.
// Depends on nrhs_pkg.
`timescale 1ns / 1ps
module nrhs_count_ram
    import nrhs_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [PosW-1:0] i_waddr,
    input  logic [CntW-1:0] i_wdata,
    input  logic [PosW-1:0] i_raddr,
    output logic [CntW-1:0] o_rdata
);
    logic [CntW-1:0] r_mem [Positions];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/nearest_request_head_scheduler_unit.sv
// nearest_request_head_scheduler_unit: top level, sequencer and count memory.
// Depends on nrhs_pkg and nrhs_count_ram.
`timescale 1ns / 1ps
// Usage
//   Input channel (i_valid/o_stall): action and position. An add (action 0)
//   bumps the pending count at position and makes no result. A serve
//   (action 1) finds the nearest pending request, moves the head there,
//   takes one request off and sends one result on the output channel
//   (o_valid/i_stall): served, moved distance, new head and total travel.
//   Config channel (i_cfg_valid/o_cfg_ready) writes track_last; ready is
//   always high, writes belong to idle periods.
//   Steps: an add reads the count, waits for the read data, then writes
//   it back; an add beyond the track is dropped. A serve probes one
//   position at a time (read, check), alternating sides, until each side
//   hits a request or its track end. A serve makes up to track_last+2
//   probes. The one memory read port sets the probe rate.
//   Reset: a clearing pass writes zero to all 1024 entries while the input
//   is stalled; head 0, direction right, total 0.
//   A held result stalls the input until the receiver takes it.
module nearest_request_head_scheduler_unit
    import nrhs_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_action,
    input  logic [PosW-1:0] i_position,
    output logic            o_valid,
    input  logic            i_stall,
    output logic            o_served,
    output logic [PosW-1:0] o_moved_distance,
    output logic [PosW-1:0] o_head_position,
    output logic [SumW-1:0] o_total_distance,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [PosW-1:0] i_cfg_data
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_ADD_RD, S_ADD_WR, S_SCAN, S_SCAN_CHK, S_DEC_RD, S_DEC_WR
    } t_state;

    t_state          r_state;
    logic [PosW-1:0] r_track_last, r_head, r_addr, r_lp, r_rp, r_lfound, r_rfound;
    logic            r_dir_right, r_have_l, r_have_r, r_l_done, r_r_done, r_side_r;
    logic [CntW-1:0] r_lcnt, r_rcnt;
    logic [SumW-1:0] r_sum;
    logic [PosW-1:0] r_clr;
    logic            r_we;
    logic [PosW-1:0] r_waddr;
    logic [CntW-1:0] r_wdata;
    logic [CntW-1:0] w_rdata;
    logic [PosW-1:0] w_top;
    logic            w_go_right;
    logic [PosW-1:0] w_dl, w_dr, w_dest, w_moved;
    logic [SumW:0]   w_sum_ext;

    assign o_cfg_ready = 1'b1;
    assign o_stall = (r_state != S_IDLE) || o_valid;
    assign w_top = (r_head < r_track_last) ? r_head : r_track_last;

    nrhs_count_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (r_we),
        .i_waddr(r_waddr),
        .i_wdata(r_wdata),
        .i_raddr(r_addr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        w_dl = r_head - r_lfound;
        w_dr = r_rfound - r_head;
        if (!r_have_l) begin
            w_go_right = 1'b1;
        end else if (!r_have_r) begin
            w_go_right = 1'b0;
        end else if (w_dl < w_dr) begin
            w_go_right = 1'b0;
        end else if (w_dl > w_dr) begin
            w_go_right = 1'b1;
        end else begin
            w_go_right = r_dir_right;
        end
        w_dest    = w_go_right ? r_rfound : r_lfound;
        w_moved   = w_go_right ? w_dr : w_dl;
        w_sum_ext = {1'b0, r_sum} + {{(SumW + 1 - PosW){1'b0}}, w_moved};
    end

    always_ff @(posedge i_clk) begin
        r_we <= 1'b0;
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_head       <= '0;
            r_dir_right  <= 1'b1;
            r_sum        <= '0;
            r_track_last <= TrackLastReset;
            o_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_track_last <= i_cfg_data;
            end
            if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_we    <= 1'b1;
                    r_waddr <= r_clr;
                    r_wdata <= '0;
                    r_clr   <= r_clr + 1'b1;
                    if (r_clr == PosW'(Positions - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        if (i_action == ActAdd) begin
                            if (i_position <= r_track_last) begin
                                r_addr  <= i_position;
                                r_state <= S_ADD_RD;
                            end
                        end else begin
                            r_have_l <= 1'b0;
                            r_have_r <= 1'b0;
                            r_l_done <= 1'b0;
                            r_r_done <= (r_head > r_track_last);
                            r_lp     <= w_top;
                            r_rp     <= r_head;
                            r_side_r <= 1'b0;
                            r_addr   <= w_top;
                            r_state  <= S_SCAN;
                        end
                    end
                end
                S_ADD_RD: r_state <= S_ADD_WR;
                S_ADD_WR: begin
                    if (w_rdata != CountMax) begin
                        r_we    <= 1'b1;
                        r_waddr <= r_addr;
                        r_wdata <= w_rdata + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                // r_addr was issued last cycle; the read data is ready in S_SCAN_CHK.
                S_SCAN: r_state <= S_SCAN_CHK;
                S_SCAN_CHK: begin
                    logic ld, rd;
                    ld = r_l_done;
                    rd = r_r_done;
                    if (!r_side_r) begin
                        if (w_rdata != '0) begin
                            r_have_l <= 1'b1;
                            r_lfound <= r_lp;
                            r_lcnt   <= w_rdata;
                            ld = 1'b1;
                        end else if (r_lp == '0) begin
                            ld = 1'b1;
                        end else begin
                            r_lp <= r_lp - 1'b1;
                        end
                    end else begin
                        if (w_rdata != '0) begin
                            r_have_r <= 1'b1;
                            r_rfound <= r_rp;
                            r_rcnt   <= w_rdata;
                            rd = 1'b1;
                        end else if (r_rp == r_track_last) begin
                            rd = 1'b1;
                        end else begin
                            r_rp <= r_rp + 1'b1;
                        end
                    end
                    r_l_done <= ld;
                    r_r_done <= rd;
                    if (ld && rd) begin
                        r_state <= S_DEC_RD;
                    end else if (!rd && (ld || !r_side_r)) begin
                        r_side_r <= 1'b1;
                        r_addr   <= (!r_side_r) ? r_rp : r_rp + 1'b1;
                        r_state  <= S_SCAN;
                    end else begin
                        r_side_r <= 1'b0;
                        r_addr   <= r_side_r ? r_lp : r_lp - 1'b1;
                        r_state  <= S_SCAN;
                    end
                end
                S_DEC_RD: begin
                    if (r_have_l || r_have_r) begin
                        r_addr  <= w_dest;
                        r_state <= S_DEC_WR;
                    end else begin
                        o_valid          <= 1'b1;
                        o_served         <= 1'b0;
                        o_moved_distance <= '0;
                        o_head_position  <= r_head;
                        o_total_distance <= r_sum;
                        r_state          <= S_IDLE;
                    end
                end
                // count at the destination was captured when the scan found it
                S_DEC_WR: begin
                    r_state <= S_IDLE;
                    r_we    <= 1'b1;
                    r_waddr <= r_addr;
                    r_wdata <= (w_go_right ? r_rcnt : r_lcnt) - 1'b1;
                    r_head  <= w_dest;
                    r_dir_right <= w_go_right;
                    r_sum   <= w_sum_ext[SumW] ? SumMax : w_sum_ext[SumW-1:0];
                    o_valid          <= 1'b1;
                    o_served         <= 1'b1;
                    o_moved_distance <= w_moved;
                    o_head_position  <= w_dest;
                    o_total_distance <= w_sum_ext[SumW] ? SumMax : w_sum_ext[SumW-1:0];
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accept while busy");
    a_served_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_served) |-> (o_moved_distance == '0)) else $error("bad idle move");
    a_sum_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) && o_served |-> (o_total_distance >= $past(r_sum)))
        else $error("total dropped");
endmodule

// File: bench/testbench.sv
// testbench: self-checking bench for nearest_request_head_scheduler_unit.
// Directed table plus random add/serve traffic, checked against a built-in SSTF predictor.
// Depends on nrhs_pkg and the scheduler RTL.
`timescale 1ns / 1ps
module testbench;
    import nrhs_pkg::*;

    // ---- clock and reset ----
    logic i_clk;
    logic i_rst_n;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---- DUT ports ----
    logic            i_valid;
    logic            o_stall;
    logic            i_action;
    logic [PosW-1:0] i_position;
    logic            o_valid;
    logic            i_stall;
    logic            o_served;
    logic [PosW-1:0] o_moved_distance;
    logic [PosW-1:0] o_head_position;
    logic [SumW-1:0] o_total_distance;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic [PosW-1:0] i_cfg_data;

    nearest_request_head_scheduler_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_action         (i_action),
        .i_position       (i_position),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_served         (o_served),
        .o_moved_distance (o_moved_distance),
        .o_head_position  (o_head_position),
        .o_total_distance (o_total_distance),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    // One serve outcome.
    typedef struct packed {
        logic            served;
        logic [PosW-1:0] moved;
        logic [PosW-1:0] head;
        logic [SumW-1:0] total;
    } t_serve_rpt;

    // ---- predictor state: own copy of the scheduler ----
    logic [CntW-1:0] req_count [Positions];
    logic [PosW-1:0] head_q;
    logic            dir_right_q;
    logic [SumW-1:0] travel_q;
    logic [PosW-1:0] track_end_q;

    t_serve_rpt pending_rpts[$];
    int         errors;
    longint     cycle_cnt;
    bit         long_hold;

    // Models one accepted transfer; pushes a report for a serve.
    function automatic void seek_predict(input logic act, input logic [PosW-1:0] pos);
        int         lo_pos;
        int         hi_pos;
        int         top;
        int         i;
        logic       go_right;
        logic [PosW-1:0] seek_len;
        t_serve_rpt r;
        lo_pos = -1;
        hi_pos = -1;
        if (act == ActAdd) begin
            if (pos <= track_end_q && req_count[pos] != CountMax)
                req_count[pos] = req_count[pos] + 1'b1;
            return;
        end
        top = (head_q < track_end_q) ? head_q : track_end_q;
        for (i = top; i >= 0; i--) begin
            if (req_count[i] != 0) begin
                lo_pos = i;
                break;
            end
        end
        if (head_q <= track_end_q) begin
            for (i = head_q; i <= track_end_q; i++) begin
                if (req_count[i] != 0) begin
                    hi_pos = i;
                    break;
                end
            end
        end
        seek_len = '0;
        r.served = (lo_pos >= 0) || (hi_pos >= 0);
        if (r.served) begin
            if (lo_pos < 0) go_right = 1'b1;
            else if (hi_pos < 0) go_right = 1'b0;
            else if (head_q - lo_pos < hi_pos - head_q) go_right = 1'b0;
            else if (head_q - lo_pos > hi_pos - head_q) go_right = 1'b1;
            else go_right = dir_right_q;
            if (go_right) begin
                seek_len = PosW'(hi_pos - head_q);
                head_q = PosW'(hi_pos);
            end else begin
                seek_len = PosW'(head_q - lo_pos);
                head_q = PosW'(lo_pos);
            end
            dir_right_q = go_right;
            req_count[head_q] = req_count[head_q] - 1'b1;
            if (SumMax - travel_q < SumW'(seek_len)) travel_q = SumMax;
            else travel_q = travel_q + SumW'(seek_len);
        end
        r.moved = seek_len;
        r.head = head_q;
        r.total = travel_q;
        pending_rpts.push_back(r);
    endfunction

    // ---- result checker ----
    always @(posedge i_clk) begin
        t_serve_rpt exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rpts.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                exp_r = pending_rpts.pop_front();
                if (o_served !== exp_r.served) begin
                    $error("served: expected %0d actual %0d", exp_r.served, o_served);
                    errors++;
                end
                if (o_moved_distance !== exp_r.moved) begin
                    $error("moved_distance: expected %0d actual %0d",
                           exp_r.moved, o_moved_distance);
                    errors++;
                end
                if (o_head_position !== exp_r.head) begin
                    $error("head_position: expected %0d actual %0d",
                           exp_r.head, o_head_position);
                    errors++;
                end
                if (o_total_distance !== exp_r.total) begin
                    $error("total_distance: expected %0d actual %0d",
                           exp_r.total, o_total_distance);
                    errors++;
                end
            end
        end
    end

    // ---- receiver stall: random gaps, one long hold-off on request ----
    always @(posedge i_clk) begin
        int hold;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (long_hold) begin
            // long stretch so the block fills up and stalls its input
            i_stall <= 1'b1;
            for (hold = 0; hold < 300; hold++) @(posedge i_clk);
            long_hold <= 1'b0;
            i_stall <= 1'b0;
        end else if (cycle_cnt[11]) begin
            i_stall <= 1'b0;  // stretches without stall
        end else begin
            i_stall <= ($urandom_range(0, 99) < 30);
        end
    end

    // ---- timeout ----
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 20_000_000) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Sends one input transfer, waits for acceptance, then an optional gap.
    task automatic send_req(input logic act, input logic [PosW-1:0] pos, input bit gaps);
        int gap;
        i_valid    <= 1'b1;
        i_action   <= act;
        i_position <= pos;
        do @(posedge i_clk); while (o_stall);
        seek_predict(act, pos);
        gap = 0;
        if (gaps) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
                  ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Waits for every result, lets the block settle, then writes track_last.
    task automatic set_track_end(input logic [PosW-1:0] val);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rpts.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);  // an add may still be in flight
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        track_end_q = val;
    endtask

    // Directed rows: after reset and extremes; expectations typed where obvious.
    typedef struct {
        logic            act;
        logic [PosW-1:0] pos;
        bit              chk;
        t_serve_rpt      want;
    } t_dir_row;

    localparam int DirRows = 16;
    t_dir_row dir_tbl [DirRows] = '{
        '{ActServe, 10'd0,    1'b1, '{1'b0, 10'd0,    10'd0,    48'd0}},  // empty
        '{ActAdd,   10'd0,    1'b0, '{1'b0, 10'd0,    10'd0,    48'd0}},
        '{ActServe, 10'd517,  1'b1, '{1'b1, 10'd0,    10'd0,    48'd0}},  // at head
        '{ActAdd,   10'd1023, 1'b0, '{1'b0, 10'd0,    10'd0,    48'd0}},
        '{ActServe, 10'd0,    1'b1, '{1'b1, 10'd1023, 10'd1023, 48'd1023}},
        '{ActAdd,   10'd0,    1'b0, '{1'b0, 10'd0,    10'd0,    48'd0}},
        '{ActServe, 10'd1023, 1'b1, '{1'b1, 10'd1023, 10'd0,    48'd2046}},
        '{ActAdd,   10'd10,   1'b0, '{1'b0, 10'd0,    10'd0,    48'd0}},
        '{ActServe, 10'd0,    1'b0, '{1'b0, 10'd0,    10'd0,    48'd0}},
        '{ActAdd,   10'd5,    1'b0, '{1'b0, 10'd0,    10'd0,    48'd0}},
        '{ActAdd,   10'd15,   1'b0, '{1'b0, 10'd0,    10'd0,    48'd0}},
        '{ActServe, 10'd0,    1'b0, '{1'b0, 10'd0,    10'd0,    48'd0}},  // tie
        '{ActServe, 10'd0,    1'b0, '{1'b0, 10'd0,    10'd0,    48'd0}},
        '{ActAdd,   10'd682,  1'b0, '{1'b0, 10'd0,    10'd0,    48'd0}},
        '{ActAdd,   10'd341,  1'b0, '{1'b0, 10'd0,    10'd0,    48'd0}},
        '{ActServe, 10'd0,    1'b0, '{1'b0, 10'd0,    10'd0,    48'd0}}
    };

    // ---- stimulus ----
    initial begin
        int k;
        int n;
        int burst;
        logic [PosW-1:0] tl_set [4] = '{10'd0, 10'd1023, 10'd63, 10'd300};
        errors      = 0;
        long_hold   = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_action    = ActAdd;
        i_position  = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        for (k = 0; k < Positions; k++) req_count[k] = '0;
        head_q      = '0;
        dir_right_q = 1'b1;
        travel_q    = '0;
        track_end_q = TrackLastReset;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: rows with chk set also get their literal value compared
        for (k = 0; k < DirRows; k++) begin
            send_req(dir_tbl[k].act, dir_tbl[k].pos, 1'b0);
            if (dir_tbl[k].chk && pending_rpts[$] !== dir_tbl[k].want) begin
                $error("directed row %0d: expected %h actual %h",
                       k, dir_tbl[k].want, pending_rpts[$]);
                errors++;
            end
        end

        // track bounds: lower the track end so an add beyond it is dropped
        set_track_end(10'd2);
        send_req(ActAdd, 10'd3, 1'b0);    // beyond the track, dropped
        send_req(ActServe, 10'd0, 1'b0);  // head is above the lowered track end here
        set_track_end(10'd1023);
        send_req(ActServe, 10'd0, 1'b0);  // stored request above old end reappears

        // back pressure: receiver holds off while serves keep coming
        long_hold <= 1'b1;
        for (k = 0; k < 12; k++) send_req(ActServe, '0, 1'b0);

        // random phases across several track settings
        for (n = 0; n < 4; n++) begin
            set_track_end(tl_set[n]);
            for (k = 0; k < 450; k++) begin
                // about half the traffic is adds, mostly at 0..127 before the last phase; the rest are serves
                if ($urandom_range(0, 9) < 5)
                    send_req(ActAdd, (n == 3 || $urandom_range(0, 3) == 0) ?
                             PosW'($urandom) : PosW'($urandom_range(0, 127)), 1'b1);
                else
                    send_req(ActServe, PosW'($urandom), 1'b1);
            end
        end

        // drain serves, then a long wait so the empty scan completes
        i_valid <= 1'b0;
        burst = 0;
        while (pending_rpts.size() != 0 && burst < 400_000) begin
            @(posedge i_clk);
            burst++;
        end
        repeat (2200) @(posedge i_clk);

        if (errors == 0 && pending_rpts.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
